@@ rtl/indexed_double_ended_queue_assert.svh @@
// ============================================================================
// indexed double-ended queue assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ============================================================================
`ifndef INDEXED_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define INDEXED_DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define IDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// condition in one cycle implies another in the next cycle
`define IDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IDQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define IDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/idq_pkg.sv @@
// ============================================================================
// idq_pkg
// Shared constants, codes, types and width helpers of the indexed deque.
// ============================================================================
package idq_pkg;

    // storage geometry
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // fixed field widths of the request and response
    localparam int OP_W    = 4;
    localparam int POS_W   = 7;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int OCNT_W  = 7;

    // helper widths
    localparam int WIDE_W = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;
    localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_POP_BACK   = 4'd2,
        OP_POP_FRONT  = 4'd3,
        OP_PEEK_BACK  = 4'd4,
        OP_PEEK_FRONT = 4'd5,
        OP_INSERT     = 4'd6,
        OP_REMOVE     = 4'd7,
        OP_READ       = 4'd8
    } t_op;

    // response status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_CAPT,
        S_SH_RD,
        S_SH_WR,
        S_WRITE,
        S_UPDATE,
        S_DONE
    } t_state;

    // single-port store command
    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_WIDTH-1:0] wdata;
    } t_mem_cmd;

    // request word to stored word
    function automatic logic [DATA_WIDTH-1:0] to_store(input logic [WORD_W-1:0] v);
        logic [WIDE_W-1:0] t;
        t = WIDE_W'(v);
        return t[DATA_WIDTH-1:0];
    endfunction

    // stored word to response word
    function automatic logic [WORD_W-1:0] to_word(input logic [DATA_WIDTH-1:0] v);
        logic [WIDE_W-1:0] t;
        t = WIDE_W'(v);
        return t[WORD_W-1:0];
    endfunction

endpackage

@@ rtl/idq_req_if.sv @@
// ============================================================================
// idq_req_if
// Request channel: operation, position and data word with valid/ready.
// ============================================================================
interface idq_req_if;
    logic                       valid;
    logic                       ready;
    logic [idq_pkg::OP_W-1:0]   operation;
    logic [idq_pkg::POS_W-1:0]  position;
    logic [idq_pkg::WORD_W-1:0] value;

    modport source (output valid, operation, position, value, input ready);
    modport sink   (input valid, operation, position, value, output ready);
endinterface

@@ rtl/idq_rsp_if.sv @@
// ============================================================================
// idq_rsp_if
// Response channel: data word, status and entry count with valid/ready.
// ============================================================================
interface idq_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [idq_pkg::WORD_W-1:0] read_value;
    logic [idq_pkg::STAT_W-1:0] status;
    logic [idq_pkg::OCNT_W-1:0] entry_count;

    modport source (output valid, read_value, status, entry_count, input ready);
    modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface

@@ rtl/idq_addr.sv @@
// ============================================================================
// idq_addr
// Shared address unit: logical position to physical store index.
// ============================================================================
module idq_addr (
    input  logic [idq_pkg::ADDR_W-1:0] i_head,
    input  logic [idq_pkg::ADDR_W-1:0] i_logical,
    output logic [idq_pkg::ADDR_W-1:0] o_phys
);
    import idq_pkg::*;

    logic [ADDR_W:0] sum;

    // head plus offset, wrapped once around the circular store
    assign sum    = {1'b0, i_head} + {1'b0, i_logical};
    assign o_phys = (sum >= (ADDR_W+1)'(DEPTH)) ? ADDR_W'(sum - (ADDR_W+1)'(DEPTH))
                                                : sum[ADDR_W-1:0];
endmodule

@@ rtl/idq_store.sv @@
// ============================================================================
// idq_store
// Entry store: one address per cycle, optional write, registered read of the old contents.
// ============================================================================
module idq_store (
    input  logic                           i_clk,
    input  idq_pkg::t_mem_cmd              i_mem,
    output logic [idq_pkg::DATA_WIDTH-1:0] o_rd_data
);
    import idq_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_mem.addr] <= i_mem.wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_mem.addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

@@ rtl/idq_ctrl.sv @@
// ============================================================================
// idq_ctrl
// Sequencer: checks each request, walks the store for shifts and reads,
// keeps head and count, and holds the response register.
// ============================================================================
`include "indexed_double_ended_queue_assert.svh"

module idq_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    idq_req_if.sink                        i_req,
    idq_rsp_if.source                      o_rsp,
    output idq_pkg::t_mem_cmd              o_mem,
    input  logic [idq_pkg::DATA_WIDTH-1:0] i_rd_data,
    output logic [idq_pkg::ADDR_W-1:0]     o_logical,
    output logic [idq_pkg::ADDR_W-1:0]     o_head,
    input  logic [idq_pkg::ADDR_W-1:0]     i_phys
);
    import idq_pkg::*;

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [ADDR_W-1:0]     r_idx, n_idx;
    logic [WORD_W-1:0]     r_rv, n_rv;
    t_status               r_st, n_st;
    logic [ADDR_W-1:0]     r_head, n_head;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    logic [WORD_W-1:0]     r_out_rv, n_out_rv;
    t_status               r_out_st, n_out_st;
    logic [OCNT_W-1:0]     r_out_cnt, n_out_cnt;

    logic              req_fire;
    logic              out_free;
    logic              full, empty;
    logic [CMP_W-1:0]  count_c, pos_c, idx_c;
    logic              pos_gt, pos_ge;
    logic [ADDR_W-1:0] idx_m1, idx_p1;
    logic              is_insert;

    // handshake and shared compares
    assign req_fire  = i_req.valid && i_req.ready;
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign full      = (r_count >= CNT_W'(DEPTH));
    assign empty     = (r_count == '0);
    assign count_c   = CMP_W'(r_count);
    assign pos_c     = CMP_W'(r_pos);
    assign idx_c     = CMP_W'(r_idx);
    assign pos_gt    = (pos_c > count_c);
    assign pos_ge    = (pos_c >= count_c);
    assign idx_m1    = r_idx - ADDR_W'(1);
    assign idx_p1    = r_idx + ADDR_W'(1);
    assign is_insert = (r_op == OP_INSERT);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                case (r_op)
                    OP_PUSH_BACK, OP_PUSH_FRONT: begin
                        n_state = full ? S_DONE : S_WRITE;
                    end
                    OP_POP_BACK, OP_POP_FRONT, OP_PEEK_BACK, OP_PEEK_FRONT: begin
                        n_state = empty ? S_DONE : S_READ;
                    end
                    OP_INSERT: begin
                        if (full || pos_gt) begin
                            n_state = S_DONE;
                        end else if (pos_c == count_c) begin
                            n_state = S_WRITE;
                        end else begin
                            n_state = S_SH_RD;
                        end
                    end
                    OP_REMOVE, OP_READ: begin
                        n_state = (empty || pos_ge) ? S_DONE : S_READ;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_READ: n_state = S_CAPT;
            S_CAPT: begin
                if ((r_op == OP_REMOVE) && ((idx_c + CMP_W'(1)) < count_c)) begin
                    n_state = S_SH_RD;
                end else begin
                    n_state = S_UPDATE;
                end
            end
            S_SH_RD: n_state = S_SH_WR;
            S_SH_WR: begin
                if (is_insert) begin
                    n_state = ((idx_c - CMP_W'(1)) == pos_c) ? S_WRITE : S_SH_RD;
                end else begin
                    n_state = ((idx_c + CMP_W'(2)) < count_c) ? S_SH_RD : S_UPDATE;
                end
            end
            S_WRITE:  n_state = S_UPDATE;
            S_UPDATE: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_op        = r_op;
        n_pos       = r_pos;
        n_val       = r_val;
        n_idx       = r_idx;
        n_rv        = r_rv;
        n_st        = r_st;
        n_head      = r_head;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_rv    = r_out_rv;
        n_out_st    = r_out_st;
        n_out_cnt   = r_out_cnt;
        o_logical   = r_idx;
        o_mem.we    = 1'b0;
        o_mem.addr  = i_phys;
        o_mem.wdata = r_val;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_op  = t_op'(i_req.operation);
                    n_pos = i_req.position;
                    n_val = to_store(i_req.value);
                    n_rv  = '0;
                    n_st  = ST_OK;
                end
            end
            S_CHECK: begin
                case (r_op)
                    OP_PUSH_BACK: begin
                        if (full) n_st = ST_FULL;
                        n_idx = ADDR_W'(r_count);
                    end
                    OP_PUSH_FRONT: begin
                        if (full) n_st = ST_FULL;
                    end
                    OP_POP_BACK, OP_PEEK_BACK: begin
                        if (empty) n_st = ST_EMPTY;
                        n_idx = ADDR_W'(r_count - CNT_W'(1));
                    end
                    OP_POP_FRONT, OP_PEEK_FRONT: begin
                        if (empty) n_st = ST_EMPTY;
                        n_idx = '0;
                    end
                    OP_INSERT: begin
                        if (full) begin
                            n_st = ST_FULL;
                        end else if (pos_gt) begin
                            n_st = ST_RANGE;
                        end
                        n_idx = ADDR_W'(r_count);
                    end
                    OP_REMOVE, OP_READ: begin
                        if (empty) begin
                            n_st = ST_EMPTY;
                        end else if (pos_ge) begin
                            n_st = ST_RANGE;
                        end
                        n_idx = ADDR_W'(r_pos);
                    end
                    default: n_st = ST_OK;
                endcase
            end
            S_READ: begin
                o_logical = r_idx;
            end
            S_CAPT: begin
                n_rv = to_word(i_rd_data);
            end
            S_SH_RD: begin
                // fetch the neighbor that moves into the cursor slot
                o_logical = is_insert ? idx_m1 : idx_p1;
            end
            S_SH_WR: begin
                o_logical   = r_idx;
                o_mem.we    = 1'b1;
                o_mem.wdata = i_rd_data;
                n_idx       = is_insert ? idx_m1 : idx_p1;
            end
            S_WRITE: begin
                o_logical   = (r_op == OP_PUSH_FRONT) ? ADDR_W'(DEPTH - 1) : r_idx;
                o_mem.we    = 1'b1;
                o_mem.wdata = r_val;
            end
            S_UPDATE: begin
                case (r_op)
                    OP_PUSH_BACK, OP_INSERT: begin
                        n_count = r_count + CNT_W'(1);
                    end
                    OP_PUSH_FRONT: begin
                        o_logical = ADDR_W'(DEPTH - 1);
                        n_head    = i_phys;
                        n_count   = r_count + CNT_W'(1);
                    end
                    OP_POP_BACK, OP_REMOVE: begin
                        n_count = r_count - CNT_W'(1);
                    end
                    OP_POP_FRONT: begin
                        o_logical = ADDR_W'(1);
                        n_head    = i_phys;
                        n_count   = r_count - CNT_W'(1);
                    end
                    default: n_count = r_count;
                endcase
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_rv    = r_rv;
                    n_out_st    = r_st;
                    n_out_cnt   = OCNT_W'(r_count);
                end
            end
            default: n_idx = r_idx;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_idx     <= n_idx;
        r_rv      <= n_rv;
        r_st      <= n_st;
        r_out_rv  <= n_out_rv;
        r_out_st  <= n_out_st;
        r_out_cnt <= n_out_cnt;
    end

    // ports
    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_value  = r_out_rv;
    assign o_rsp.status      = r_out_st;
    assign o_rsp.entry_count = r_out_cnt;
    assign o_head            = r_head;

    // checks
    `IDQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "count above depth")
    `IDQ_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, r_state != S_UPDATE, $stable(r_count), "count moved outside update")
    `IDQ_ASSERT_NEXT(a_head_hold, i_clk, i_rst_n, r_state != S_UPDATE, $stable(r_head), "head moved outside update")
    `IDQ_ASSERT(a_write_ok, i_clk, i_rst_n, !o_mem.we || (r_st == ST_OK), "store written by failed request")
    `IDQ_ASSERT_NEXT(a_accept_check, i_clk, i_rst_n, req_fire, r_state == S_CHECK, "accepted request not checked")
endmodule

@@ rtl/indexed_double_ended_queue.sv @@
// ============================================================================
// indexed_double_ended_queue
// Bounded deque with push, pop and peek at both ends plus indexed insert,
// remove and read; one response per request.
// ============================================================================
// One request is taken at a time; ready is high only while the sequencer is
// idle. The entry store has a single port used for one read or one write per
// cycle, so the cost of a request is set by its store accesses: push back and
// push front write once, failed requests and unknown codes make no access,
// pop, peek and read make one read, insert at position p with n entries
// shifts the n - p entries from p on back by one and then writes, remove
// at p reads its entry and moves the n - 1 - p entries behind it forward,
// each shifted entry one read and one write through the shared address unit.
// The response sits in an output register, so a finished response may wait
// for the consumer while the block is already working on the next request.
// No clearing pass follows reset; the queue is empty and usable at once.
module indexed_double_ended_queue (
    input  logic      i_clk,
    input  logic      i_rst_n,
    idq_req_if.sink   i_req,
    idq_rsp_if.source o_rsp
);
    import idq_pkg::*;

    t_mem_cmd              mem_cmd;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [ADDR_W-1:0]     logical;
    logic [ADDR_W-1:0]     head;
    logic [ADDR_W-1:0]     phys;

    // sequencer
    idq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_mem     (mem_cmd),
        .i_rd_data (rd_data),
        .o_logical (logical),
        .o_head    (head),
        .i_phys    (phys)
    );

    // shared address unit
    idq_addr u_addr (
        .i_head    (head),
        .i_logical (logical),
        .o_phys    (phys)
    );

    // entry store
    idq_store u_store (
        .i_clk     (i_clk),
        .i_mem     (mem_cmd),
        .o_rd_data (rd_data)
    );
endmodule

@@ bench/indexed_double_ended_queue_checker.sv @@
// ============================================================================
// indexed_double_ended_queue_checker
// Watches the request and response channels of the indexed deque. Every
// accepted request runs through a shadow deque that works out the response
// it must produce. Each accepted response is compared field by field with
// the oldest outstanding prediction, and failures are counted for the top.
// ============================================================================
module indexed_double_ended_queue_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    idq_req_if                         i_req,
    idq_rsp_if                         i_rsp,
    output int                         o_fail_count,
    output int                         o_outstanding,
    output logic [idq_pkg::OCNT_W-1:0] o_entry_level
);
    timeunit 1ns;
    timeprecision 1ps;

    import idq_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [WORD_W-1:0] read_value;
        t_status           status;
        logic [OCNT_W-1:0] entry_count;
    } t_response;

    // logical deque content, index 0 is the front
    logic [DATA_WIDTH-1:0] deque_contents[$];
    // predicted responses in request order
    t_response             pending_responses[$];
    int                    response_index;

    // apply one request to the shadow deque and return its response
    function automatic t_response apply_deque_op(input logic [OP_W-1:0]   op,
                                                 input logic [POS_W-1:0]  pos,
                                                 input logic [WORD_W-1:0] val);
        t_response             rsp;
        int unsigned           n;
        logic [DATA_WIDTH-1:0] word;
        rsp        = '0;
        rsp.status = ST_OK;
        n          = deque_contents.size();
        word       = DATA_WIDTH'(val);
        case (op)
            OP_PUSH_BACK: begin
                if (n >= DEPTH) rsp.status = ST_FULL;
                else deque_contents.push_back(word);
            end
            OP_PUSH_FRONT: begin
                if (n >= DEPTH) rsp.status = ST_FULL;
                else deque_contents.push_front(word);
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
                if (n == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.read_value = WORD_W'(deque_contents[n-1]);
                    if (op == OP_POP_BACK) void'(deque_contents.pop_back());
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
                if (n == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.read_value = WORD_W'(deque_contents[0]);
                    if (op == OP_POP_FRONT) void'(deque_contents.pop_front());
                end
            end
            // full wins over a bad position
            OP_INSERT: begin
                if (n >= DEPTH) rsp.status = ST_FULL;
                else if (pos > n) rsp.status = ST_RANGE;
                else deque_contents.insert(int'(pos), word);
            end
            OP_REMOVE: begin
                if (n == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (pos >= n) begin
                    rsp.status = ST_RANGE;
                end else begin
                    rsp.read_value = WORD_W'(deque_contents[pos]);
                    deque_contents.delete(int'(pos));
                end
            end
            OP_READ: begin
                if (n == 0) rsp.status = ST_EMPTY;
                else if (pos >= n) rsp.status = ST_RANGE;
                else rsp.read_value = WORD_W'(deque_contents[pos]);
            end
            // unused codes leave everything alone
            default: begin
            end
        endcase
        rsp.entry_count = OCNT_W'(deque_contents.size());
        return rsp;
    endfunction

    // count a failure, print only the first few
    task automatic flag_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT) $display("%s", msg);
    endtask

    // predict on accepted requests, compare on accepted responses
    always @(posedge i_clk) begin : monitor
        t_response want;
        if (!i_rst_n) begin
            deque_contents.delete();
            pending_responses.delete();
            response_index = 0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                pending_responses.push_back(
                    apply_deque_op(i_req.operation, i_req.position, i_req.value));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_responses.size() == 0) begin
                    flag_failure($sformatf(
                        "response %0d with no request pending: value %h status %0d count %0d",
                        response_index, i_rsp.read_value, i_rsp.status,
                        i_rsp.entry_count));
                end else begin
                    want = pending_responses.pop_front();
                    if (i_rsp.read_value !== want.read_value ||
                        i_rsp.status !== want.status ||
                        i_rsp.entry_count !== want.entry_count) begin
                        flag_failure($sformatf(
                            "response %0d: expected value %h status %0d count %0d, %s %h %0d %0d",
                            response_index, want.read_value, want.status,
                            want.entry_count, "got", i_rsp.read_value, i_rsp.status,
                            i_rsp.entry_count));
                    end
                end
                response_index++;
            end
        end
        o_outstanding = pending_responses.size();
        o_entry_level = OCNT_W'(deque_contents.size());
    end

endmodule

@@ bench/indexed_double_ended_queue_tb.sv @@
// ============================================================================
// indexed_double_ended_queue_tb
// Drives push, pop, peek, insert, remove and read requests into the indexed
// deque: a directed pass over the empty and out-of-range cases, then
// random episodes that fill the queue, drain it and mix operations. The
// sender works in bursts and the receiver stalls on its own pattern,
// including one long hold-off. A checker beside the block scores responses.
// ============================================================================
module indexed_double_ended_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import idq_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1030;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT  = 3000;
    localparam int OP_SLOTS     = 10;

    localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

    typedef enum int unsigned {
        TREND_GROW,
        TREND_SHRINK,
        TREND_MIX
    } t_trend;

    // weights in percent, columns follow the operation codes, last one unused codes
    localparam int unsigned OP_WEIGHT [3][OP_SLOTS] = '{
        '{30, 20,  2,  2,  3,  3, 25,  5,  7, 3},
        '{ 4,  3, 22, 20,  4,  4,  4, 25, 11, 3},
        '{11, 11, 11, 11, 11, 11, 11, 11,  9, 3}
    };

    logic              i_clk;
    logic              i_rst_n;
    int                fail_count;
    int                outstanding;
    logic [OCNT_W-1:0] entry_level;
    bit                long_hold_req;
    int                burst_left;
    int                items_sent;

    idq_req_if req_ch ();
    idq_rsp_if rsp_ch ();

    indexed_double_ended_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    indexed_double_ended_queue_checker deque_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_entry_level (entry_level)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // offer one request, then maybe a gap when the burst runs out
    task automatic offer_request(input logic [OP_W-1:0]   op,
                                 input logic [POS_W-1:0]  pos,
                                 input logic [WORD_W-1:0] val);
        int unsigned gap;
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.position  <= pos;
        req_ch.value     <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // random request biased toward filling, draining or neither
    task automatic random_request(input t_trend trend);
        int unsigned       n;
        int unsigned       roll;
        int unsigned       slot;
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] val;
        n    = entry_level;
        roll = $urandom_range(0, 99);
        slot = 0;
        while (roll >= OP_WEIGHT[trend][slot]) begin
            roll -= OP_WEIGHT[trend][slot];
            slot++;
        end
        if (slot < OP_SLOTS - 1) op = OP_W'(slot);
        else op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        // mostly legal positions, with the boundaries and full-range noise
        case ($urandom_range(0, 9))
            0: pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
            1: pos = POS_W'(n);
            2: pos = (n == 0) ? '0 : POS_W'(n - 1);
            default: pos = POS_W'($urandom_range(0, n));
        endcase
        case ($urandom_range(0, 9))
            0: val = '0;
            1: val = '1;
            default: val = $urandom;
        endcase
        items_sent++;
        offer_request(op, pos, val);
    endtask

    // stop offering until every request has been answered
    task automatic wait_all_answered();
        req_ch.valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge i_clk);
    endtask

    // response side: stall patterns in segments, plus the long hold-off
    initial begin : response_sink
        int unsigned style;
        bit          hold_done;
        hold_done    = 1'b0;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            style = $urandom_range(0, 3);
            repeat ($urandom_range(10, 150)) begin
                @(negedge i_clk);
                if (long_hold_req && !hold_done) begin
                    rsp_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                    hold_done = 1'b1;
                end else begin
                    case (style)
                        0: rsp_ch.ready <= 1'b1;
                        1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                        2: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                        default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
                    endcase
                end
            end
        end
    end

    // watchdog on cycles with no accepted request or response
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (req_ch.valid && req_ch.ready) ||
                (rsp_ch.valid && rsp_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("indexed_double_ended_queue_tb failed");
        $finish;
    end

    // request stimulus and verdict
    initial begin : stimulus
        int unsigned episode;
        int unsigned guard;
        t_trend      trend;
        long_hold_req    = 1'b0;
        items_sent       = 0;
        req_ch.valid     = 1'b0;
        req_ch.operation = '0;
        req_ch.position  = '0;
        req_ch.value     = '0;
        i_rst_n          = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n    = 1'b1;
        burst_left = $urandom_range(1, 40);

        // every pop, peek, remove and read on an empty queue, plus a bad insert
        offer_request(OP_POP_BACK,   '0, '0);
        offer_request(OP_POP_FRONT,  '0, '0);
        offer_request(OP_PEEK_BACK,  '0, '0);
        offer_request(OP_PEEK_FRONT, '0, '0);
        offer_request(OP_REMOVE,     '0, '0);
        offer_request(OP_READ,       '0, '0);
        offer_request(OP_INSERT,     7'd1, 32'h0bad_f00d);
        // build a short queue by insert, push back and push front
        offer_request(OP_INSERT,     '0, '1);
        offer_request(OP_PUSH_BACK,  '0, '0);
        offer_request(OP_PUSH_FRONT, '0, 32'ha5c3_3c5a);
        // positions past the back, then legal inserts, reads and removes
        offer_request(OP_READ,       7'd3, '0);
        offer_request(OP_READ,       '1, '1);
        offer_request(OP_REMOVE,     7'd3, '0);
        offer_request(OP_INSERT,     7'd4, 32'h5555_aaaa);
        offer_request(OP_INSERT,     7'd3, 32'h1234_5678);
        offer_request(OP_INSERT,     7'd2, 32'h8000_0001);
        offer_request(OP_PEEK_BACK,  '0, '0);
        offer_request(OP_PEEK_FRONT, '0, '0);
        offer_request(OP_READ,       7'd1, '0);
        offer_request(OP_REMOVE,     7'd1, '0);
        offer_request(OP_REMOVE,     '0, '0);
        // unused codes at both ends of their range
        offer_request(OP_UNUSED_LO,  7'd5, '1);
        offer_request(OP_UNUSED_HI,  '1, '1);
        offer_request(OP_POP_BACK,   '0, '0);
        offer_request(OP_POP_FRONT,  '0, '0);
        wait_all_answered();

        // random episodes: fill to full, drain to empty, or mix
        episode = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (episode == 0) trend = TREND_GROW;
            else if (episode == 1) trend = TREND_SHRINK;
            else trend = t_trend'($urandom_range(0, 2));
            if (trend == TREND_MIX) begin
                repeat ($urandom_range(20, 80)) random_request(trend);
            end else begin
                guard = 0;
                while (guard < 400 && ((trend == TREND_GROW) ?
                       (entry_level < DEPTH) : (entry_level != 0))) begin
                    random_request(trend);
                    guard++;
                end
                // stay at the limit for a while
                repeat ($urandom_range(5, 20)) random_request(trend);
            end
            // long receiver hold-off while requests keep coming back to back
            if (episode == 2) begin
                long_hold_req = 1'b1;
                burst_left    = 41;
                repeat (40) random_request(TREND_MIX);
            end
            if (episode == 5) wait_all_answered();
            episode++;
        end

        wait_all_answered();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("indexed_double_ended_queue_tb passed");
        end else begin
            $display("indexed_double_ended_queue_tb failed");
        end
        $finish;
    end

endmodule
